/* hw/rtl/qknob_pkg.sv */
// ----------------------------------------------------------------------------
// qknob_pkg
// types, codes and the quadrature transition table of the knob decoder
// ----------------------------------------------------------------------------
package qknob_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int TIME_W      = 32;
    localparam int CFG_TIME_W  = 31;
    localparam int SPD_W       = 4;
    localparam int ACC_W       = 5;

    // item kinds
    localparam logic [1:0] CMD_AB     = 2'd0;
    localparam logic [1:0] CMD_BUTTON = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    // result codes
    localparam logic [1:0] ROT_NONE = 2'd0;
    localparam logic [1:0] ROT_CW   = 2'd1;
    localparam logic [1:0] ROT_CCW  = 2'd2;
    localparam logic [1:0] BTN_NONE  = 2'd0;
    localparam logic [1:0] BTN_SHORT = 2'd1;
    localparam logic [1:0] BTN_LONG  = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_STEPS_PER_DETENT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INVERT_DIRECTION   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TIME_US   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_TIME_US = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_AB_PHASE   = 3'd4;

    // reset values
    localparam logic [SPD_W-1:0]      RST_STEPS_PER_DETENT   = 4'd4;
    localparam logic                  RST_INVERT_DIRECTION   = 1'b1;
    localparam logic [CFG_TIME_W-1:0] RST_DEBOUNCE_TIME_US   = 31'd15000;
    localparam logic [CFG_TIME_W-1:0] RST_LONG_PRESS_TIME_US = 31'd2000000;
    localparam logic [1:0]            RST_INITIAL_AB_PHASE   = 2'h3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [1:0]        ab_phase;
        logic              button_level;
        logic [TIME_W-1:0] now_us;
    } in_t;

    typedef struct packed {
        logic [1:0] rotate_event;
        logic [1:0] button_event;
    } out_t;

    // direction from {last phase, new phase}
    function automatic logic signed [1:0] quad_dir(input logic [3:0] idx);
        logic signed [1:0] d;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
            default: d = 2'sd0;
        endcase
        return d;
    endfunction

endpackage

/* hw/rtl/quadrature_knob_with_press_classifier_top.sv */
// ----------------------------------------------------------------------------
// quadrature_knob_with_press_classifier_top
// path: an item passes from input transfer through the input reg, then the result reg
// throughput: one item per cycle unless out_ready stalls the result reg; state updates as each item moves on
// reset: asynchronous active low, registers at defaults, last phase 3, no hold
// ----------------------------------------------------------------------------
module quadrature_knob_with_press_classifier_top
    import qknob_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_t                    in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_t                   out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [SPD_W-1:0]      steps_reg;
    logic                  invert_reg;
    logic [CFG_TIME_W-1:0] debounce_reg;
    logic [CFG_TIME_W-1:0] long_reg;

    logic                  s1_valid_reg;
    in_t                   s1_data_reg;
    logic                  out_valid_reg;
    out_t                  out_data_reg;

    logic [1:0]            last_phase_reg, last_phase_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic                  pressed_reg, pressed_next;
    logic                  long_rep_reg, long_rep_next;
    logic [TIME_W-1:0]     change_time_reg, change_time_next;
    logic [TIME_W-1:0]     start_time_reg, start_time_next;
    out_t                  res;

    logic                  out_take;
    logic                  s1_move;

    logic signed [1:0]     dir;
    logic signed [ACC_W:0] spd;
    logic signed [ACC_W:0] sum;
    logic [TIME_W-1:0]     since_change;
    logic [TIME_W-1:0]     held;
    logic                  skip_check;

    assign cfg_ready = 1'b1;

    // configuration; phase load applies only at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg    <= RST_STEPS_PER_DETENT;
            invert_reg   <= RST_INVERT_DIRECTION;
            debounce_reg <= RST_DEBOUNCE_TIME_US;
            long_reg     <= RST_LONG_PRESS_TIME_US;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_STEPS_PER_DETENT:   steps_reg    <= cfg_data[SPD_W-1:0];
                REG_INVERT_DIRECTION:   invert_reg   <= cfg_data[0];
                REG_DEBOUNCE_TIME_US:   debounce_reg <= cfg_data[CFG_TIME_W-1:0];
                REG_LONG_PRESS_TIME_US: long_reg     <= cfg_data[CFG_TIME_W-1:0];
                REG_INITIAL_AB_PHASE:   ;
                default:                ;
            endcase
        end
    end

    // handshake
    assign out_take  = !out_valid_reg || out_ready;
    assign s1_move   = s1_valid_reg && out_take;
    assign in_ready  = !s1_valid_reg || out_take;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_take)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_move)
        begin
            out_data_reg <= res;
        end
    end

    // item processing
    always_comb
    begin
        last_phase_next  = last_phase_reg;
        acc_next         = acc_reg;
        pressed_next     = pressed_reg;
        long_rep_next    = long_rep_reg;
        change_time_next = change_time_reg;
        start_time_next  = start_time_reg;
        res.rotate_event = ROT_NONE;
        res.button_event = BTN_NONE;
        skip_check       = 1'b0;

        dir = quad_dir({last_phase_reg, s1_data_reg.ab_phase});
        if (invert_reg)
        begin
            dir = -dir;
        end
        spd = (steps_reg == '0) ? (ACC_W+1)'(1) : $signed({2'b00, steps_reg});
        sum = $signed({acc_reg[ACC_W-1], acc_reg}) + (ACC_W+1)'(dir);
        since_change = s1_data_reg.now_us - change_time_reg;
        held         = s1_data_reg.now_us - start_time_reg;

        case (s1_data_reg.cmd)
            CMD_AB:
            begin
                last_phase_next = s1_data_reg.ab_phase;
                if (dir != 2'sd0)
                begin
                    if (sum >= spd)
                    begin
                        acc_next         = ACC_W'(sum - spd);
                        res.rotate_event = ROT_CW;
                    end
                    else if (sum <= -spd)
                    begin
                        acc_next         = ACC_W'(sum + spd);
                        res.rotate_event = ROT_CCW;
                    end
                    else
                    begin
                        acc_next = ACC_W'(sum);
                    end
                end
            end
            CMD_BUTTON:
            begin
                if (!s1_data_reg.button_level)
                begin
                    if (since_change < {1'b0, debounce_reg})
                    begin
                        skip_check = 1'b1;
                    end
                    else
                    begin
                        change_time_next = s1_data_reg.now_us;
                        if (!pressed_reg)
                        begin
                            pressed_next    = 1'b1;
                            start_time_next = s1_data_reg.now_us;
                            long_rep_next   = 1'b0;
                        end
                    end
                end
                else if (pressed_reg)
                begin
                    change_time_next = s1_data_reg.now_us;
                    pressed_next     = 1'b0;
                    long_rep_next    = 1'b0;
                    if (held < {1'b0, debounce_reg})
                    begin
                        skip_check = 1'b1;
                    end
                    else if (!long_rep_reg)
                    begin
                        res.button_event = (held >= {1'b0, long_reg}) ? BTN_LONG : BTN_SHORT;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // mid-hold long press
        if (!skip_check && pressed_next && !long_rep_next &&
            (s1_data_reg.now_us - start_time_next) >= {1'b0, long_reg})
        begin
            long_rep_next    = 1'b1;
            res.button_event = BTN_LONG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_phase_reg  <= RST_INITIAL_AB_PHASE;
            acc_reg         <= '0;
            pressed_reg     <= 1'b0;
            long_rep_reg    <= 1'b0;
            change_time_reg <= '0;
            start_time_reg  <= '0;
        end
        else if (s1_move)
        begin
            last_phase_reg  <= last_phase_next;
            acc_reg         <= acc_next;
            pressed_reg     <= pressed_next;
            long_rep_reg    <= long_rep_next;
            change_time_reg <= change_time_next;
            start_time_reg  <= start_time_next;
        end
    end

endmodule

/* hw/rtl/qknob_checker.sv */
// ----------------------------------------------------------------------------
// qknob_checker
// port-level checks of the knob decoder, bound to the top level
// ----------------------------------------------------------------------------
module qknob_checker
    import qknob_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    // stalled result stays
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result dropped or changed");

    // no result without an earlier input transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without input transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.rotate_event == ROT_NONE ||
                      out_data.rotate_event == ROT_CW ||
                      out_data.rotate_event == ROT_CCW)
        else $error("bad rotate code");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.button_event == BTN_NONE ||
                      out_data.button_event == BTN_SHORT ||
                      out_data.button_event == BTN_LONG)
        else $error("bad button code");

endmodule

bind quadrature_knob_with_press_classifier_top qknob_checker u_qknob_checker (.*);
